### sv/imu_bias_scale_ema_filter_macros.svh
// Assertion macros for the IMU bias/scale/EMA filter.
// Included by the top level; no other dependencies.
`ifndef IMU_BIAS_SCALE_EMA_FILTER_MACROS_SVH
`define IMU_BIAS_SCALE_EMA_FILTER_MACROS_SVH

`ifndef SYNTHESIS
`define IBSEF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ibsef: implication check failed");
`define IBSEF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ibsef: next-cycle check failed");
`else
`define IBSEF_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define IBSEF_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

### sv/ibsef_pkg.sv
// Shared types and constants for the IMU bias/scale/EMA filter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ibsef_pkg;

  localparam int OUT_FRAC_BITS = 16;
  localparam int ACCEL_SHIFT   = 24 - OUT_FRAC_BITS;
  localparam int GYRO_SHIFT    = 28 - OUT_FRAC_BITS;

  localparam int NUM_AXES  = 6;
  localparam int NUM_GYRO  = 3;
  localparam int DIV_BITS  = 36;

  localparam logic [2:0] AXIS_GYRO0 = 3'd3;
  localparam logic [2:0] AXIS_LAST  = 3'd5;
  localparam logic [1:0] CAL_LAST   = 2'd2;

  localparam logic [15:0] ALPHA_ONE = 16'd32768;

  // input item kinds
  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_CAL     = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_ACCEL_GAIN  = 3'd0;
  localparam logic [2:0] REG_GYRO_GAIN   = 3'd1;
  localparam logic [2:0] REG_ACCEL_ALPHA = 3'd2;
  localparam logic [2:0] REG_GYRO_ALPHA  = 3'd3;
  localparam logic [2:0] REG_CAL_LENGTH  = 3'd4;
  localparam logic [2:0] REG_BIAS_X      = 3'd5;
  localparam logic [2:0] REG_BIAS_Y      = 3'd6;
  localparam logic [2:0] REG_BIAS_Z      = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCL_MUL,
    ST_SCL_FIN,
    ST_EMA_MUL,
    ST_EMA_FIN,
    ST_DIV_LOAD,
    ST_DIV_STEP,
    ST_DIV_FIN,
    ST_OUT
  } ibsef_state_t;

endpackage

`default_nettype wire

### sv/imu_bias_scale_ema_filter.sv
// Top level of the IMU bias/scale/EMA filter: sequencer, shared multiplier, divider.
// Depends on ibsef_pkg and imu_bias_scale_ema_filter_macros.svh.
//
//  port group                      dir  handshake            content
//  in_valid/in_ready + fields      in   valid/ready          kind, raw accel/gyro, stamp
//  out_valid/out_ready + fields    out  valid/ready          filtered axes, stamp, bias src
//  cfg_valid/cfg_ready/cfg_index   in   valid/ready          register write, cfg_data
//
// Data sample: accepted in ST_IDLE, then per axis ST_SCL_MUL, ST_SCL_FIN on the first
// sample after reset or restart, else also ST_EMA_MUL, ST_EMA_FIN (two passes through the
// shared 33x23 multiplier), then ST_OUT. Calibration and restart items finish in ST_IDLE
// alone; the item that completes an estimate then runs the serial divider per gyro axis.
// Synchronous reset returns the control, filter and config registers to defaults. A full
// output register holds the sequencer in ST_OUT until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "imu_bias_scale_ema_filter_macros.svh"

module imu_bias_scale_ema_filter import ibsef_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [21:0]        cfg_data,
  // input items
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         kind,
  input  wire logic signed [15:0] acc_x,
  input  wire logic signed [15:0] acc_y,
  input  wire logic signed [15:0] acc_z,
  input  wire logic signed [15:0] rate_x,
  input  wire logic signed [15:0] rate_y,
  input  wire logic signed [15:0] rate_z,
  input  wire logic [47:0]        stamp,
  // results
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      filt_acc_x,
  output logic signed [31:0]      filt_acc_y,
  output logic signed [31:0]      filt_acc_z,
  output logic signed [31:0]      filt_rate_x,
  output logic signed [31:0]      filt_rate_y,
  output logic signed [31:0]      filt_rate_z,
  output logic [47:0]             out_stamp,
  output logic                    bias_from_cal
);

  // configuration registers
  logic [21:0]        accel_gain;
  logic [21:0]        gyro_gain;
  logic [15:0]        accel_alpha;
  logic [15:0]        gyro_alpha;
  logic [15:0]        cal_length;
  logic signed [19:0] man_bias [NUM_GYRO];

  // filter and calibration state
  logic signed [31:0] ema [NUM_AXES];
  logic               ema_loaded;
  logic signed [33:0] cal_sums [NUM_GYRO];
  logic [15:0]        cal_seen;
  logic signed [19:0] cal_bias [NUM_GYRO];
  logic               cal_done;

  // working registers
  ibsef_state_t       state, state_next;
  logic [2:0]         axis;
  logic signed [15:0] raw [NUM_AXES];
  logic [47:0]        stamp_q;
  logic signed [31:0] scaled;
  logic signed [55:0] prod;
  logic [DIV_BITS-1:0] div_quo;
  logic [16:0]        div_rem;
  logic [5:0]         div_cnt;
  logic               div_neg;

  // control decode
  logic               ema_phase;
  logic               out_load;

  // datapath nets
  logic [1:0]         gyro_idx;
  logic [1:0]         cal_idx;
  logic               is_gyro;
  logic signed [19:0] bias_sel;
  logic signed [20:0] gyro_diff;
  logic [15:0]        alpha_raw;
  logic [15:0]        alpha_eff;
  logic signed [32:0] mul_a;
  logic signed [22:0] mul_b;
  logic signed [31:0] scaled_c;
  logic signed [55:0] ema_acc;
  logic signed [31:0] ema_new;
  logic [16:0]        seen_inc;
  logic [15:0]        cal_need;
  logic               cal_complete;
  logic signed [37:0] div_num;
  logic [37:0]        div_mag;
  logic [16:0]        rem_sh;
  logic               rem_ge;
  logic signed [15:0] rate_in [NUM_GYRO];

  function automatic logic signed [31:0] rnd_sat(input logic signed [55:0] v, input int s);
    logic signed [55:0] r;
    r = (s == 0) ? v : ((v + (56'sd1 <<< (s - 1))) >>> s);
    if (r > 56'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (r < -56'sd2147483648) begin
      return 32'sh80000000;
    end
    return r[31:0];
  endfunction

  assign cfg_ready = 1'b1;

  assign rate_in[0] = rate_x;
  assign rate_in[1] = rate_y;
  assign rate_in[2] = rate_z;

  // calibration progress seen at accept time
  assign seen_inc     = {1'b0, cal_seen} + 17'd1;
  assign cal_need     = (cal_length == 16'd0) ? 16'd1 : cal_length;
  assign cal_complete = (seen_inc[15:0] >= cal_need) && (seen_inc[15:0] != 16'd0);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (kind == KIND_DATA) begin
            state_next = ST_SCL_MUL;
          end else if (kind == KIND_CAL && cal_complete) begin
            state_next = ST_DIV_LOAD;
          end
        end
      end
      ST_SCL_MUL: state_next = ST_SCL_FIN;
      ST_SCL_FIN: begin
        if (ema_loaded) begin
          state_next = ST_EMA_MUL;
        end else if (axis == AXIS_LAST) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_SCL_MUL;
        end
      end
      ST_EMA_MUL: state_next = ST_EMA_FIN;
      ST_EMA_FIN: state_next = (axis == AXIS_LAST) ? ST_OUT : ST_SCL_MUL;
      ST_DIV_LOAD: state_next = ST_DIV_STEP;
      ST_DIV_STEP: begin
        if (div_cnt == 6'(DIV_BITS - 1)) begin
          state_next = ST_DIV_FIN;
        end
      end
      ST_DIV_FIN: state_next = (cal_idx == CAL_LAST) ? ST_IDLE : ST_DIV_LOAD;
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    ema_phase = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      ST_IDLE:    in_ready  = 1'b1;
      ST_EMA_MUL: ema_phase = 1'b1;
      ST_OUT:     out_load  = !out_valid || out_ready;
      default: begin
      end
    endcase
  end

  // shared multiplier operands
  always_comb begin
    gyro_idx  = 2'(axis - AXIS_GYRO0);
    cal_idx   = axis[1:0];
    is_gyro   = axis >= AXIS_GYRO0;
    bias_sel  = cal_done ? cal_bias[gyro_idx] : man_bias[gyro_idx];
    gyro_diff = (21'(raw[axis]) <<< 4) - 21'(bias_sel);
    alpha_raw = is_gyro ? gyro_alpha : accel_alpha;
    alpha_eff = (alpha_raw > ALPHA_ONE) ? ALPHA_ONE : alpha_raw;
    if (ema_phase) begin
      // a*x + (1-a)*old == old + a*(x - old), alpha in Q15
      mul_a = 33'(scaled) - 33'(ema[axis]);
      mul_b = signed'({7'd0, alpha_eff});
    end else begin
      mul_a = is_gyro ? 33'(gyro_diff) : 33'(raw[axis]);
      mul_b = signed'({1'b0, is_gyro ? gyro_gain : accel_gain});
    end
  end

  always_comb begin
    scaled_c = is_gyro ? rnd_sat(prod, GYRO_SHIFT) : rnd_sat(prod, ACCEL_SHIFT);
    ema_acc  = (56'(ema[axis]) <<< 15) + prod + 56'sd16384;
    ema_new  = ema_acc[46:15];
    div_num  = 38'(cal_sums[cal_idx]) <<< 4;
    div_mag  = div_num[37] ? 38'(-div_num) : 38'(div_num);
    rem_sh   = {div_rem[15:0], div_quo[DIV_BITS-1]};
    rem_ge   = rem_sh >= {1'b0, cal_seen};
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      axis        <= 3'd0;
      accel_gain  <= 22'd4096;
      gyro_gain   <= 22'd524288;
      accel_alpha <= 16'd655;
      gyro_alpha  <= 16'd655;
      cal_length  <= 16'd5000;
      ema_loaded  <= 1'b0;
      cal_seen    <= 16'd0;
      cal_done    <= 1'b0;
      out_valid   <= 1'b0;
      div_cnt     <= 6'd0;
      for (int i = 0; i < NUM_GYRO; i++) begin
        man_bias[i] <= 20'sd0;
        cal_sums[i] <= 34'sd0;
        cal_bias[i] <= 20'sd0;
      end
      for (int i = 0; i < NUM_AXES; i++) begin
        ema[i] <= 32'sd0;
      end
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ACCEL_GAIN:  accel_gain  <= cfg_data;
          REG_GYRO_GAIN:   gyro_gain   <= cfg_data;
          REG_ACCEL_ALPHA: accel_alpha <= cfg_data[15:0];
          REG_GYRO_ALPHA:  gyro_alpha  <= cfg_data[15:0];
          REG_CAL_LENGTH:  cal_length  <= cfg_data[15:0];
          REG_BIAS_X:      man_bias[0] <= signed'(cfg_data[19:0]);
          REG_BIAS_Y:      man_bias[1] <= signed'(cfg_data[19:0]);
          REG_BIAS_Z:      man_bias[2] <= signed'(cfg_data[19:0]);
        endcase
      end

      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          axis <= 3'd0;
          if (in_valid) begin
            if (kind == KIND_RESTART) begin
              ema_loaded <= 1'b0;
              for (int i = 0; i < NUM_AXES; i++) begin
                ema[i] <= 32'sd0;
              end
            end else if (kind == KIND_CAL) begin
              for (int i = 0; i < NUM_GYRO; i++) begin
                cal_sums[i] <= cal_sums[i] + 34'(rate_in[i]);
              end
              cal_seen <= seen_inc[15:0];
            end
          end
        end
        ST_SCL_FIN: begin
          scaled <= scaled_c;
          if (!ema_loaded) begin
            ema[axis] <= scaled_c;
            axis      <= axis + 3'd1;
          end
        end
        ST_EMA_FIN: begin
          ema[axis] <= ema_new;
          axis      <= axis + 3'd1;
        end
        ST_DIV_LOAD: begin
          div_quo <= DIV_BITS'(div_mag) + DIV_BITS'(cal_seen >> 1);
          div_neg <= div_num[37];
          div_rem <= 17'd0;
          div_cnt <= 6'd0;
        end
        ST_DIV_STEP: begin
          div_rem <= rem_ge ? (rem_sh - {1'b0, cal_seen}) : rem_sh;
          div_quo <= {div_quo[DIV_BITS-2:0], rem_ge};
          div_cnt <= div_cnt + 6'd1;
        end
        ST_DIV_FIN: begin
          cal_bias[cal_idx] <= div_neg ? -signed'(div_quo[19:0]) : signed'(div_quo[19:0]);
          axis              <= axis + 3'd1;
          if (cal_idx == CAL_LAST) begin
            cal_seen <= 16'd0;
            cal_done <= 1'b1;
            for (int i = 0; i < NUM_GYRO; i++) begin
              cal_sums[i] <= 34'sd0;
            end
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_valid  <= 1'b1;
            ema_loaded <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // latch the item on accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      raw[0]  <= acc_x;
      raw[1]  <= acc_y;
      raw[2]  <= acc_z;
      raw[3]  <= rate_x;
      raw[4]  <= rate_y;
      raw[5]  <= rate_z;
      stamp_q <= stamp;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      filt_acc_x    <= ema[0];
      filt_acc_y    <= ema[1];
      filt_acc_z    <= ema[2];
      filt_rate_x   <= ema[3];
      filt_rate_y   <= ema[4];
      filt_rate_z   <= ema[5];
      out_stamp     <= stamp_q;
      bias_from_cal <= cal_done;
    end
  end

  `IBSEF_ASSERT_NXT(a_cal_finish, clk, rst, (state == ST_DIV_FIN) && (cal_idx == CAL_LAST),
                    (cal_seen == 16'd0) && cal_done && (state == ST_IDLE))
  `IBSEF_ASSERT_NXT(a_out_load, clk, rst, out_load, out_valid && ema_loaded)
  `IBSEF_ASSERT_IMP(a_div_count, clk, rst, state == ST_DIV_STEP,
                    div_cnt <= 6'(DIV_BITS - 1))
  `IBSEF_ASSERT_IMP(a_axis_range, clk, rst, (state != ST_IDLE) && (state != ST_OUT),
                    axis <= AXIS_LAST)

endmodule

`default_nettype wire

### bench/imu_bias_scale_ema_filter_tb.sv
// Self-checking bench for imu_bias_scale_ema_filter: random and directed samples,
// register writes between phases, scoreboard with its own bias/scale/EMA predictor.
// Depends on ibsef_pkg and the filter RTL.
`timescale 1ns / 1ps

module imu_bias_scale_ema_filter_tb;
  import ibsef_pkg::*;

  localparam logic [1:0] KIND_IGNORED = 2'd3;

  localparam int NUM_PHASES    = 14;
  localparam int PHASE_ITEMS   = 92;
  localparam int HOLD_PHASE    = 2;
  localparam int DRAIN_PHASE   = 5;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 200;
  localparam int MAX_REPORTS   = 10;
  localparam int LIMIT_NS      = 20_000_000;

  localparam longint INT32_HI = 64'sd2147483647;
  localparam longint INT32_LO = -64'sd2147483648;

  localparam logic [15:0] RAW_MAX = 16'h7FFF;
  localparam logic [15:0] RAW_MIN = 16'h8000;

  typedef struct packed {
    logic [1:0]       kind;
    logic [2:0][15:0] acc;
    logic [2:0][15:0] rate;
    logic [47:0]      stamp;
  } imu_item_t;

  typedef struct packed {
    logic [5:0][31:0] axis;
    logic [47:0]      stamp;
    logic             from_cal;
  } filt_result_t;

  class filter_scoreboard;
    logic [21:0]        accel_gain, gyro_gain;
    logic [15:0]        accel_alpha, gyro_alpha, cal_length;
    logic signed [19:0] manual_bias [3];
    logic signed [31:0] ema_acc [6];
    bit                 ema_primed;
    longint             cal_sum [3];
    logic [15:0]        cal_count;
    logic signed [19:0] cal_bias [3];
    bit                 cal_valid;
    filt_result_t       pending_results [$];
    int                 mismatches;

    function new();
      accel_gain  = 22'd4096;
      gyro_gain   = 22'd524288;
      accel_alpha = 16'd655;
      gyro_alpha  = 16'd655;
      cal_length  = 16'd5000;
      for (int i = 0; i < 3; i++) begin
        manual_bias[i] = '0;
        cal_sum[i]     = 0;
        cal_bias[i]    = '0;
      end
      for (int i = 0; i < 6; i++) ema_acc[i] = '0;
      ema_primed = 0;
      cal_count  = '0;
      cal_valid  = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [21:0] data);
      case (idx)
        REG_ACCEL_GAIN:  accel_gain = data;
        REG_GYRO_GAIN:   gyro_gain = data;
        REG_ACCEL_ALPHA: accel_alpha = data[15:0];
        REG_GYRO_ALPHA:  gyro_alpha = data[15:0];
        REG_CAL_LENGTH:  cal_length = data[15:0];
        REG_BIAS_X:      manual_bias[0] = data[19:0];
        REG_BIAS_Y:      manual_bias[1] = data[19:0];
        REG_BIAS_Z:      manual_bias[2] = data[19:0];
        default: ;
      endcase
    endfunction

    // floor((v + half) / 2^s)
    function longint shift_round(longint v, int s);
      longint x;
      if (s == 0) return v;
      x = v + (longint'(1) <<< (s - 1));
      return x >>> s;
    endfunction

    function logic signed [31:0] clamp32(longint v);
      if (v > INT32_HI) return INT32_HI[31:0];
      if (v < INT32_LO) return INT32_LO[31:0];
      return v[31:0];
    endfunction

    function logic signed [31:0] ema_step(logic signed [31:0] old, logic signed [31:0] x,
                                          logic [15:0] alpha);
      longint a, acc;
      a = (alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha);
      acc = a * longint'(x) + (longint'(ALPHA_ONE) - a) * longint'(old);
      return clamp32(shift_round(acc, 15));
    endfunction

    function void note_input(imu_item_t it);
      filt_result_t       r;
      logic signed [31:0] scaled [6];
      longint             bias, prod, num;
      longint unsigned    mag, q;
      logic [15:0]        need;
      case (it.kind)
        KIND_RESTART: begin
          for (int i = 0; i < 6; i++) ema_acc[i] = '0;
          ema_primed = 0;
        end
        KIND_CAL: begin
          need = (cal_length == 16'd0) ? 16'd1 : cal_length;
          for (int i = 0; i < 3; i++) cal_sum[i] += longint'($signed(it.rate[i]));
          cal_count = cal_count + 16'd1;
          if (cal_count >= need && cal_count != 16'd0) begin
            // mean in LSB Q4, ties away from zero
            for (int i = 0; i < 3; i++) begin
              num = cal_sum[i] * 16;
              mag = (num < 0) ? -num : num;
              q = (mag + cal_count / 2) / cal_count;
              cal_bias[i] = 20'((num < 0) ? -longint'(q) : longint'(q));
              cal_sum[i] = 0;
            end
            cal_count = '0;
            cal_valid = 1;
          end
        end
        KIND_DATA: begin
          for (int i = 0; i < 3; i++) begin
            bias = cal_valid ? longint'(cal_bias[i]) : longint'(manual_bias[i]);
            prod = longint'($signed(it.acc[i])) * longint'(accel_gain);
            scaled[i] = clamp32(shift_round(prod, ACCEL_SHIFT));
            prod = (longint'($signed(it.rate[i])) * 16 - bias) * longint'(gyro_gain);
            scaled[3 + i] = clamp32(shift_round(prod, GYRO_SHIFT));
          end
          for (int i = 0; i < 6; i++) begin
            if (!ema_primed) begin
              ema_acc[i] = scaled[i];
            end else begin
              ema_acc[i] = ema_step(ema_acc[i], scaled[i], (i < 3) ? accel_alpha : gyro_alpha);
            end
            r.axis[i] = ema_acc[i];
          end
          ema_primed = 1;
          r.stamp = it.stamp;
          r.from_cal = cal_valid;
          pending_results.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void report(string what, longint want_v, longint got_v);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t mismatch on %s: expected %0d, got %0d", $time, what, want_v, got_v);
    endfunction

    function void check_result(filt_result_t got);
      filt_result_t want;
      string        axis_names [6] = '{"filt_acc_x", "filt_acc_y", "filt_acc_z",
                                       "filt_rate_x", "filt_rate_y", "filt_rate_z"};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t result with nothing pending, out_stamp %0d", $time, got.stamp);
        return;
      end
      want = pending_results.pop_front();
      for (int i = 0; i < 6; i++)
        if (got.axis[i] !== want.axis[i])
          report(axis_names[i], $signed(want.axis[i]), $signed(got.axis[i]));
      if (got.stamp !== want.stamp) report("out_stamp", want.stamp, got.stamp);
      if (got.from_cal !== want.from_cal) report("bias_from_cal", want.from_cal, got.from_cal);
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [2:0]          cfg_index;
  logic [21:0]         cfg_data;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          kind;
  logic signed [15:0]  acc_x, acc_y, acc_z;
  logic signed [15:0]  rate_x, rate_y, rate_z;
  logic [47:0]         stamp;
  logic                out_valid;
  logic                out_ready;
  logic signed [31:0]  filt_acc_x, filt_acc_y, filt_acc_z;
  logic signed [31:0]  filt_rate_x, filt_rate_y, filt_rate_z;
  logic [47:0]         out_stamp;
  logic                bias_from_cal;

  filter_scoreboard    sb;
  logic [7:0][21:0]    cur_cfg;
  bit                  tx_gappy;
  bit                  rx_gappy;
  bit                  hold_out;

  imu_bias_scale_ema_filter DUT (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  // every accepted transaction goes to the scoreboard; results first
  always @(posedge clk) begin : monitor
    imu_item_t    it;
    filt_result_t res;
    if (!rst) begin
      if (out_valid && out_ready) begin
        res.axis[0] = filt_acc_x;
        res.axis[1] = filt_acc_y;
        res.axis[2] = filt_acc_z;
        res.axis[3] = filt_rate_x;
        res.axis[4] = filt_rate_y;
        res.axis[5] = filt_rate_z;
        res.stamp = out_stamp;
        res.from_cal = bias_from_cal;
        sb.check_result(res);
      end
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        it.kind = kind;
        it.acc[0] = acc_x;
        it.acc[1] = acc_y;
        it.acc[2] = acc_z;
        it.rate[0] = rate_x;
        it.rate[1] = rate_y;
        it.rate[2] = rate_z;
        it.stamp = stamp;
        sb.note_input(it);
      end
    end
  end

  function automatic int draw_gap(bit gappy);
    return gappy ? $urandom_range(0, 14) : 0;
  endfunction

  initial begin : receiver
    int gap;
    out_ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (hold_out) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_out = 0;
      end else begin
        gap = draw_gap(rx_gappy);
        if (gap > 0) begin
          out_ready = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  function automatic logic [15:0] pick_raw();
    logic [31:0] r;
    r = $urandom;
    case (r[2:0])
      3'd0: return RAW_MIN;
      3'd1: return RAW_MAX;
      3'd2: return 16'h0000;
      3'd3: return 16'hFFFF;
      default: return r[31:16];
    endcase
  endfunction

  function automatic imu_item_t mk_item(logic [1:0] k, logic [15:0] ax, logic [15:0] ay,
                                        logic [15:0] az, logic [15:0] rx, logic [15:0] ry,
                                        logic [15:0] rz, logic [47:0] st);
    imu_item_t it;
    it.kind = k;
    it.acc[0] = ax;
    it.acc[1] = ay;
    it.acc[2] = az;
    it.rate[0] = rx;
    it.rate[1] = ry;
    it.rate[2] = rz;
    it.stamp = st;
    return it;
  endfunction

  function automatic imu_item_t rand_item(logic [1:0] k);
    imu_item_t   it;
    logic [31:0] r;
    it.kind = k;
    for (int i = 0; i < 3; i++) begin
      it.acc[i] = pick_raw();
      it.rate[i] = pick_raw();
    end
    r = $urandom;
    case (r[1:0])
      2'd0: it.stamp = '0;
      2'd1: it.stamp = '1;
      default: it.stamp = {r[31:16], $urandom};
    endcase
    return it;
  endfunction

  task automatic send_item(imu_item_t it);
    int gap;
    gap = draw_gap(tx_gappy);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    kind = it.kind;
    acc_x = it.acc[0];
    acc_y = it.acc[1];
    acc_z = it.acc[2];
    rate_x = it.rate[0];
    rate_y = it.rate[1];
    rate_z = it.rate[2];
    stamp = it.stamp;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic program_regs(logic [7:0][21:0] vals);
    for (int i = 0; i < 8; i++) begin
      cfg_index = 3'(i);
      cfg_data = vals[i];
      cfg_valid = 1'b1;
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drain();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // no result marks the end of a calibration item, so let the divider finish too
  task automatic wait_idle();
    in_valid = 1'b0;
    wait_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [21:0] with_junk(logic [21:0] v, int w);
    logic [21:0] mask, r;
    mask = ~((22'd1 << w) - 22'd1);
    r = 22'($urandom);
    return ($urandom_range(0, 3) == 0) ? (v | (r & mask)) : v;
  endfunction

  function automatic logic [21:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return 22'd0;
      1: return 22'd1;
      2: return 22'd2097152;
      3: return 22'h3FFFFF;
      4: return 22'($urandom_range(1, 8192));
      5: return 22'($urandom_range(1, 2097152));
      default: return 22'($urandom_range(2048, 1048576));
    endcase
  endfunction

  function automatic logic [21:0] pick_alpha();
    case ($urandom_range(0, 7))
      0: return 22'd0;
      1: return 22'd32768;
      2: return 22'd65535;
      3: return 22'($urandom_range(32769, 65535));
      default: return 22'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic logic [21:0] pick_bias();
    logic [31:0] r;
    r = $urandom;
    case (r[1:0])
      2'd0: return 22'h080000;
      2'd1: return 22'h07FFFF;
      2'd2: return 22'd0;
      default: return {2'b00, r[31:12]};
    endcase
  endfunction

  function automatic void randomize_config();
    logic [21:0] len;
    case ($urandom_range(0, 9))
      0: len = 22'd0;
      1: len = 22'd65535;
      2: len = 22'd32;
      default: len = 22'($urandom_range(1, 6));
    endcase
    cur_cfg[REG_ACCEL_GAIN]  = pick_gain();
    cur_cfg[REG_GYRO_GAIN]   = pick_gain();
    cur_cfg[REG_ACCEL_ALPHA] = with_junk(pick_alpha(), 16);
    cur_cfg[REG_GYRO_ALPHA]  = with_junk(pick_alpha(), 16);
    cur_cfg[REG_CAL_LENGTH]  = with_junk(len, 16);
    cur_cfg[REG_BIAS_X]      = with_junk(pick_bias(), 20);
    cur_cfg[REG_BIAS_Y]      = with_junk(pick_bias(), 20);
    cur_cfg[REG_BIAS_Z]      = with_junk(pick_bias(), 20);
  endfunction

  initial begin : stimulus
    int          count;
    int          act;
    int          burst;
    bit          drained;
    logic [15:0] len;

    sb = new();
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    kind = KIND_DATA;
    acc_x = '0;
    acc_y = '0;
    acc_z = '0;
    rate_x = '0;
    rate_y = '0;
    rate_z = '0;
    stamp = '0;
    tx_gappy = 1;
    rx_gappy = 1;
    hold_out = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset register values, field extremes, restart and an ignored kind
    send_item(mk_item(KIND_DATA, RAW_MAX, RAW_MAX, RAW_MAX, RAW_MAX, RAW_MAX, RAW_MAX, '1));
    send_item(mk_item(KIND_DATA, RAW_MIN, RAW_MIN, RAW_MIN, RAW_MIN, RAW_MIN, RAW_MIN, '0));
    send_item(mk_item(KIND_DATA, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 48'h5A5A_A5A5_0F0F));
    send_item(mk_item(KIND_RESTART, RAW_MAX, RAW_MIN, 16'h1, 16'hFFFF, 16'h0, RAW_MAX, '1));
    send_item(mk_item(KIND_DATA, RAW_MAX, RAW_MIN, 16'h0001, 16'hFFFF, RAW_MIN, RAW_MAX,
                      48'hA5A5_5A5A_F0F0));
    send_item(mk_item(KIND_IGNORED, RAW_MIN, RAW_MAX, 16'h0, RAW_MIN, RAW_MAX, 16'h0, '1));
    send_item(mk_item(KIND_DATA, 16'h1234, 16'hEDCB, 16'h7000, 16'h0010, 16'hFFF0, 16'h8001,
                      48'h0000_0000_0001));

    // zero accel gain, alpha above one, zero calibration length, bias extremes
    wait_idle();
    cur_cfg[REG_ACCEL_GAIN]  = 22'd0;
    cur_cfg[REG_GYRO_GAIN]   = 22'h3FFFFF;
    cur_cfg[REG_ACCEL_ALPHA] = 22'h3FFFFF;
    cur_cfg[REG_GYRO_ALPHA]  = 22'd0;
    cur_cfg[REG_CAL_LENGTH]  = 22'h3F0000;
    cur_cfg[REG_BIAS_X]      = 22'h07FFFF;
    cur_cfg[REG_BIAS_Y]      = 22'h380000;
    cur_cfg[REG_BIAS_Z]      = 22'd0;
    program_regs(cur_cfg);
    send_item(mk_item(KIND_DATA, RAW_MAX, RAW_MAX, RAW_MAX, RAW_MAX, RAW_MAX, RAW_MAX, '1));
    send_item(mk_item(KIND_DATA, RAW_MIN, RAW_MIN, RAW_MIN, RAW_MIN, RAW_MIN, RAW_MIN, '0));
    send_item(mk_item(KIND_CAL, 16'h0, 16'h0, 16'h0, RAW_MIN, RAW_MAX, 16'h0, '0));
    send_item(mk_item(KIND_DATA, RAW_MAX, RAW_MIN, RAW_MAX, 16'h0, 16'h0, 16'h0, '1));
    send_item(mk_item(KIND_RESTART, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, '0));
    send_item(mk_item(KIND_DATA, 16'h0100, 16'hFF00, 16'h0, RAW_MAX, RAW_MIN, 16'h0001, '1));

    // recalibration: old calibrated bias holds until the new estimate completes
    wait_idle();
    cur_cfg[REG_ACCEL_GAIN]  = 22'd2097152;
    cur_cfg[REG_GYRO_GAIN]   = 22'd1;
    cur_cfg[REG_ACCEL_ALPHA] = 22'd32768;
    cur_cfg[REG_GYRO_ALPHA]  = 22'd1;
    cur_cfg[REG_CAL_LENGTH]  = 22'd20;
    program_regs(cur_cfg);
    send_item(mk_item(KIND_CAL, 16'h0, 16'h0, 16'h0, RAW_MAX, RAW_MIN, 16'h0003, '0));
    send_item(mk_item(KIND_CAL, 16'h0, 16'h0, 16'h0, RAW_MAX, RAW_MIN, 16'hFFFD, '0));
    send_item(mk_item(KIND_CAL, 16'h0, 16'h0, 16'h0, RAW_MAX, RAW_MIN, 16'h0001, '0));
    send_item(mk_item(KIND_DATA, RAW_MAX, RAW_MIN, 16'h0, RAW_MAX, RAW_MIN, 16'h0, '1));

    // length lowered below the count already seen: next calibration item completes
    wait_idle();
    cur_cfg[REG_CAL_LENGTH] = 22'd2;
    program_regs(cur_cfg);
    send_item(mk_item(KIND_CAL, 16'h0, 16'h0, 16'h0, 16'h0, RAW_MAX, 16'h0002, '0));
    send_item(mk_item(KIND_DATA, 16'h0, 16'h0, 16'h0, RAW_MIN, RAW_MAX, 16'h0, 48'h1));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      randomize_config();
      program_regs(cur_cfg);
      len = cur_cfg[REG_CAL_LENGTH][15:0];
      tx_gappy = ($urandom_range(0, 3) != 0);
      rx_gappy = ($urandom_range(0, 3) != 0);
      if (ph == HOLD_PHASE) begin
        // receiver stalls while the sender keeps offering: the block backs up
        tx_gappy = 0;
        hold_out = 1;
      end
      count = 0;
      drained = 0;
      while (count < PHASE_ITEMS) begin
        if (ph == DRAIN_PHASE && !drained && count >= PHASE_ITEMS / 2) begin
          in_valid = 1'b0;
          wait_drain();
          drained = 1;
        end
        act = $urandom_range(0, 99);
        if (act < 55) begin
          send_item(rand_item(KIND_DATA));
          count++;
        end else if (act < 70) begin
          // a full calibration run when the length is small enough
          if (len == 16'd0) burst = 1;
          else if (len <= 16'd32) burst = len;
          else burst = $urandom_range(1, 4);
          repeat (burst) send_item(rand_item(KIND_CAL));
          count += burst;
        end else if (act < 80) begin
          send_item(rand_item(KIND_CAL));
          count++;
        end else if (act < 92) begin
          send_item(rand_item(KIND_RESTART));
          count++;
        end else begin
          send_item(rand_item(KIND_IGNORED));
        end
      end
    end

    wait_idle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
